FILE: src/gbs_pkg.sv
// shared types and constants for the greedy box suppression block
package gbs_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned SizeW   = 15;
  localparam int unsigned ThreshW = 16;
  localparam int unsigned NumW    = 10;
  localparam logic [ThreshW-1:0] ThreshReset = 16'd29491;

  // one box as it travels through the block
  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic [SizeW-1:0]         width;
    logic [SizeW-1:0]         height;
  } box_t;

  // word from the front part to the back part
  typedef struct packed {
    logic            frame_start;
    box_t            box;
    logic [NumW-1:0] number;
  } job_t;

  // back part sequencer states
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StDone = 4'b0100,
    StOut  = 4'b1000
  } state_e;

endpackage

FILE: src/gbs_front.sv
// front part: accepts boxes, numbers them within the frame, queues them
module gbs_front import gbs_pkg::*; #(
  parameter int unsigned NumLimit = 1023
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic frame_start_i,
  input  box_t box_i,
  output logic job_valid_o,
  input  logic job_ready_i,
  output job_t job_o
);

  logic [NumW-1:0] cnt_q, cnt_d, num;
  job_t q_mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] fill_q;
  logic push, pop;

  assign in_ready_o  = (fill_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign job_valid_o = (fill_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = q_mem_q[rp_q];

  // box number, restarts at frame start, saturates
  always_comb begin
    num   = frame_start_i ? '0 : cnt_q;
    cnt_d = cnt_q;
    if (push) begin
      cnt_d = (num < NumW'(NumLimit)) ? num + 1'b1 : num;
    end
  end

  // two entry queue toward the back part
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wp_q] <= '{frame_start: frame_start_i, box: box_i, number: num};
    end
  end

  // queue never overflows or underflows
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= 2'd2)
    else $error("queue fill out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !frame_start_i && cnt_q < NumW'(NumLimit)) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("box counter did not advance");

endmodule

FILE: src/gbs_back.sv
// back part: scans the kept list with one shared overlap unit
module gbs_back import gbs_pkg::*; #(
  parameter int unsigned MaxKept = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [ThreshW-1:0] thresh_i,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  job_t               job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               keep_o,
  output logic [NumW-1:0]    box_number_o,
  output logic               store_full_o,
  output logic               busy_o
);

  localparam int unsigned IdxW = (MaxKept > 1) ? $clog2(MaxKept) : 1;
  localparam int unsigned CntW = $clog2(MaxKept + 1);

  box_t mem_q [MaxKept];
  box_t cur_q, rd_q;
  state_e state_q, state_d;
  logic [CntW-1:0] count_q, idx_q;
  logic keep_q, full_q, rd_ok_q;
  logic [NumW-1:0] num_q;

  // overlap pipeline registers
  logic [16:0] ix_q, iy_q;
  logic [29:0] ca_q, ka_q;
  logic        p1_q;
  logic [33:0] inter_q;
  logic [31:0] uni_q;
  logic        p2_q;
  logic [49:0] lhs_q;
  logic [47:0] rhs_q;
  logic        p3_q;
  logic        pend;

  // intersection extents, exact at 18 bits
  function automatic logic [16:0] ovl(input logic signed [15:0] a0, input logic [14:0] aw,
                                      input logic signed [15:0] b0, input logic [14:0] bw);
    logic signed [17:0] a1, b1, lo, hi;
    begin
      a1 = 18'(a0) + $signed({3'b0, aw});
      b1 = 18'(b0) + $signed({3'b0, bw});
      lo = (18'(a0) > 18'(b0)) ? 18'(a0) : 18'(b0);
      hi = (a1 < b1) ? a1 : b1;
      ovl = (hi > lo) ? 17'(hi - lo) : '0;
    end
  endfunction

  assign job_ready_o  = state_q[0];
  assign out_valid_o  = state_q[3];
  assign keep_o       = keep_q;
  assign box_number_o = num_q;
  assign store_full_o = full_q;
  assign busy_o       = !state_q[0];
  assign pend         = rd_ok_q || p1_q || p2_q || p3_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (job_valid_i) state_d = StScan;
      StScan: if (idx_q >= count_q && !pend) state_d = StDone;
      StDone: state_d = StOut;
      StOut:  if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      idx_q   <= '0;
      rd_ok_q <= 1'b0;
      p1_q    <= 1'b0;
      p2_q    <= 1'b0;
      p3_q    <= 1'b0;
      keep_q  <= 1'b0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_ok_q <= 1'b0;
      p1_q    <= rd_ok_q;
      p2_q    <= p1_q;
      p3_q    <= p2_q;
      case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            if (job_i.frame_start) count_q <= '0;
            idx_q  <= '0;
            keep_q <= 1'b1;
            full_q <= 1'b0;
          end
        end
        StScan: begin
          if (idx_q < count_q) begin
            idx_q   <= idx_q + 1'b1;
            rd_ok_q <= 1'b1;
          end
          if (p3_q && (lhs_q > {2'b0, rhs_q})) keep_q <= 1'b0;
        end
        StDone: begin
          if (keep_q) begin
            if (count_q < CntW'(MaxKept)) count_q <= count_q + 1'b1;
            else full_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // kept list memory, read and write registered
  always_ff @(posedge clk_i) begin
    if (state_q[0] && job_valid_i) begin
      cur_q <= job_i.box;
      num_q <= job_i.number;
    end
    if (state_q[1]) rd_q <= mem_q[idx_q[IdxW-1:0]];
    if (state_q[2] && keep_q && count_q < CntW'(MaxKept)) begin
      mem_q[count_q[IdxW-1:0]] <= cur_q;
    end
    // stage one: extents and areas
    ix_q <= ovl(cur_q.left, cur_q.width, rd_q.left, rd_q.width);
    iy_q <= ovl(cur_q.top, cur_q.height, rd_q.top, rd_q.height);
    ca_q <= 30'(cur_q.width) * 30'(cur_q.height);
    ka_q <= 30'(rd_q.width) * 30'(rd_q.height);
    // stage two: intersection and union
    inter_q <= 34'(ix_q) * 34'(iy_q);
    uni_q   <= 32'(ca_q) + 32'(ka_q) - 32'(32'(ix_q) * 32'(iy_q));
    // stage three: compare terms
    lhs_q <= {inter_q[33:0], 16'b0};
    rhs_q <= 48'(thresh_i) * 48'(uni_q);
  end

  // exactly one state at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(MaxKept))
    else $error("kept count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && full_q) |-> keep_q) else $error("full flag without keep");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");

endmodule

FILE: src/greedy_box_suppression.sv
// top level of the greedy box suppression block
//  channel | handshake                 | word
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_data_i (iou threshold, Q0.16)
//  in      | in_valid_i / in_ready_o   | frame_start_i, box_*_i
//  out     | out_valid_o / out_ready_i | keep_o, box_number_o, store_full_o
// the back part takes a box in the idle state, then scans with one kept list read per cycle,
// drains the memory read and the three stage overlap unit, updates the list and presents
// the result.
// a two entry queue lets the front accept boxes while the back part scans.
// reset empties the list and box counter and loads the 0.45 threshold; no clearing pass.
// the result register holds while out_ready_i is low; the back part then stalls.
module greedy_box_suppression import gbs_pkg::*; #(
  parameter int unsigned MAX_KEPT  = 64,
  parameter int unsigned MAX_BOXES = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [ThreshW-1:0]       cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     frame_start_i,
  input  logic signed [CoordW-1:0] box_left_i,
  input  logic signed [CoordW-1:0] box_top_i,
  input  logic [SizeW-1:0]         box_width_i,
  input  logic [SizeW-1:0]         box_height_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     keep_o,
  output logic [NumW-1:0]          box_number_o,
  output logic                     store_full_o
);

  localparam int unsigned NumLimit = (MAX_BOXES - 1 > 1023) ? 1023 : MAX_BOXES - 1;

  logic [ThreshW-1:0] thresh_q;
  logic job_valid, job_ready, busy;
  job_t job;
  box_t box;

  assign box = '{left: box_left_i, top: box_top_i, width: box_width_i,
                 height: box_height_i};
  assign cfg_ready_o = 1'b1;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thresh_q <= ThreshReset;
    else if (cfg_valid_i) thresh_q <= cfg_data_i;
  end

  gbs_front #(.NumLimit(NumLimit)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .frame_start_i,
    .box_i(box), .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  gbs_back #(.MaxKept(MAX_KEPT)) u_back (
    .clk_i, .rst_ni, .thresh_i(thresh_q), .job_valid_i(job_valid),
    .job_ready_o(job_ready), .job_i(job), .out_valid_o, .out_ready_i,
    .keep_o, .box_number_o, .store_full_o, .busy_o(busy)
  );

  // a result only comes from a busy back part
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> busy)
    else $error("result while back part idle");

endmodule

FILE: verif/tb_greedy_box_suppression.sv
// self-checking testbench for the greedy box suppression block
`timescale 1ns / 100ps

module tb_greedy_box_suppression;
  import gbs_pkg::*;

  localparam int unsigned KeptMax    = 64;
  localparam int unsigned NumberTop  = 1023;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleWait = 100;

  typedef enum int {
    ModeCluster,
    ModeGrid,
    ModeNoise,
    ModeMix
  } gen_mode_e;

  typedef struct {
    logic                     frame_start;
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic [SizeW-1:0]         width;
    logic [SizeW-1:0]         height;
  } box_item_t;

  typedef struct {
    logic            keep;
    logic [NumW-1:0] number;
    logic            full;
  } verdict_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [ThreshW-1:0]       cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     frame_start_i;
  logic signed [CoordW-1:0] box_left_i;
  logic signed [CoordW-1:0] box_top_i;
  logic [SizeW-1:0]         box_width_i;
  logic [SizeW-1:0]         box_height_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     keep_o;
  logic [NumW-1:0]          box_number_o;
  logic                     store_full_o;

  greedy_box_suppression uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .frame_start_i (frame_start_i),
    .box_left_i    (box_left_i),
    .box_top_i     (box_top_i),
    .box_width_i   (box_width_i),
    .box_height_i  (box_height_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .keep_o        (keep_o),
    .box_number_o  (box_number_o),
    .store_full_o  (store_full_o)
  );

  // predictor state
  box_item_t          kept_list [KeptMax];
  int unsigned        kept_total;
  int unsigned        box_counter;
  logic [ThreshW-1:0] thresh;

  box_item_t   pending_boxes[$];
  verdict_t    expected_verdicts[$];
  box_item_t   held_box;
  int unsigned errors;
  int unsigned cycles;
  int unsigned boxes_sent;
  int unsigned kept_seen;
  int unsigned suppressed_seen;
  int unsigned full_seen;
  int unsigned saturated_seen;
  int unsigned in_gap;
  int unsigned out_stall;
  bit          no_idle;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // greedy suppression verdict for one box, updates predictor state
  function automatic verdict_t judge_box(input box_item_t b);
    verdict_t v;
    longint cx0, cy0, cx1, cy1, carea;
    longint kx0, ky0, kx1, ky1, karea;
    longint ix, iy, inter, uni;
    if (b.frame_start) begin
      kept_total  = 0;
      box_counter = 0;
    end
    cx0   = longint'(b.left);
    cy0   = longint'(b.top);
    cx1   = cx0 + longint'(b.width);
    cy1   = cy0 + longint'(b.height);
    carea = longint'(b.width) * longint'(b.height);
    v.keep = 1'b1;
    v.full = 1'b0;
    for (int i = 0; i < kept_total; i++) begin
      kx0   = longint'(kept_list[i].left);
      ky0   = longint'(kept_list[i].top);
      kx1   = kx0 + longint'(kept_list[i].width);
      ky1   = ky0 + longint'(kept_list[i].height);
      karea = longint'(kept_list[i].width) * longint'(kept_list[i].height);
      ix = ((cx1 < kx1) ? cx1 : kx1) - ((cx0 > kx0) ? cx0 : kx0);
      iy = ((cy1 < ky1) ? cy1 : ky1) - ((cy0 > ky0) ? cy0 : ky0);
      if (ix < 0) ix = 0;
      if (iy < 0) iy = 0;
      inter = ix * iy;
      uni   = carea + karea - inter;
      if ((inter << 16) > longint'(thresh) * uni) v.keep = 1'b0;
    end
    if (v.keep) begin
      if (kept_total < KeptMax) begin
        kept_list[kept_total] = b;
        kept_total++;
      end else begin
        v.full = 1'b1;
      end
    end
    v.number = box_counter[NumW-1:0];
    if (box_counter < NumberTop) box_counter++;
    return v;
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
  endtask

  function automatic box_item_t mk_box(input bit fs, input int l, input int t,
                                       input int w, input int h);
    box_item_t b;
    b.frame_start = fs;
    b.left        = l[CoordW-1:0];
    b.top         = t[CoordW-1:0];
    b.width       = w[SizeW-1:0];
    b.height      = h[SizeW-1:0];
    return b;
  endfunction

  // append one box to the pending list
  function automatic void queue_box(input box_item_t b);
    pending_boxes = {pending_boxes, b};
  endfunction

  // box source: clustered overlaps, boxes in grid cells, raw bits, or a mix of them
  task automatic add_frame(input int n, input gen_mode_e mode);
    box_item_t b;
    gen_mode_e m;
    int ax, ay, k;
    ax = $urandom_range(0, 4000) - 2000;
    ay = $urandom_range(0, 4000) - 2000;
    for (int i = 0; i < n; i++) begin
      m = mode;
      if (mode == ModeMix) m = gen_mode_e'($urandom_range(0, 9) < 5 ? ModeCluster :
                                           ($urandom_range(0, 4) == 0 ? ModeNoise : ModeGrid));
      case (m)
        ModeCluster: begin
          b = mk_box(0, ax + $urandom_range(0, 400), ay + $urandom_range(0, 400),
                     $urandom_range(0, 800), $urandom_range(0, 800));
        end
        ModeGrid: begin
          k = $urandom_range(0, 2047);
          b = mk_box(0, (k % 64) * 512 - 16384 + $urandom_range(0, 40),
                     (k / 64) * 512 - 8192 + $urandom_range(0, 40),
                     $urandom_range(1, 300), $urandom_range(1, 300));
        end
        default: begin
          b = mk_box(0, $urandom, $urandom, $urandom, $urandom);
          // stray frame starts only in pure noise frames, long frames stay whole
          if (mode == ModeNoise && $urandom_range(0, 40) == 0) b.frame_start = 1'b1;
        end
      endcase
      if (i == 0) b.frame_start = 1'b1;
      queue_box(b);
    end
  endtask

  // let everything drain so the block is idle
  task automatic drain;
    while (pending_boxes.size() != 0 || in_valid_i || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_thresh(input logic [ThreshW-1:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    thresh = val;
    no_idle = ($urandom_range(0, 3) == 0);
  endtask

  // stimulus sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    out_ready_i   = 1'b0;
    frame_start_i = 1'b0;
    box_left_i    = '0;
    box_top_i     = '0;
    box_width_i   = '0;
    box_height_i  = '0;
    kept_total    = 0;
    box_counter   = 0;
    thresh        = ThreshReset;
    errors        = 0;
    no_idle       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: first boxes without a frame start, then edge cases
    queue_box(mk_box(0, 100, 100, 200, 200));
    queue_box(mk_box(0, 100, 100, 200, 200));    // identical, suppressed
    queue_box(mk_box(0, 300, 300, 200, 200));    // touching corner
    queue_box(mk_box(1, 0, 0, 0, 0));            // zero area
    queue_box(mk_box(0, 0, 0, 0, 0));            // zero union
    queue_box(mk_box(0, 0, 0, 0, 500));
    queue_box(mk_box(0, -32768, -32768, 32767, 32767));
    queue_box(mk_box(0, 32767, 32767, 32767, 32767));
    queue_box(mk_box(0, -32768, 32767, 32767, 1));
    queue_box(mk_box(0, -32768, -32768, 32767, 32767)); // repeat of kept
    queue_box(mk_box(0, -32000, -32000, 32767, 32000)); // heavy overlap
    queue_box(mk_box(0, 150, 100, 200, 200));
    queue_box(mk_box(0, 1000, 1000, 100, 100));
    queue_box(mk_box(0, 1045, 1000, 100, 100));  // near threshold
    queue_box(mk_box(0, 1046, 1000, 100, 100));
    queue_box(mk_box(1, 5, 5, 1, 1));
    queue_box(mk_box(0, 5, 5, 1, 1));
    queue_box(mk_box(0, 32767, -32768, 0, 32767));
    add_frame(10, ModeCluster);

    // lowest threshold: any overlap suppresses
    write_thresh(16'd0);
    add_frame(16, ModeCluster);
    queue_box(mk_box(0, 0, 0, 0, 0));

    // highest threshold, list overflow
    write_thresh(16'hFFFF);
    add_frame(68, ModeGrid);

    // long frame that saturates the box counter
    write_thresh(16'($urandom));
    add_frame(1026, ModeMix);

    // back to the reset value, mixed short frames
    write_thresh(ThreshReset);
    for (int f = 0; f < 3; f++) add_frame($urandom_range(1, 10), ModeMix);
    write_thresh(16'($urandom_range(1000, 60000)));
    for (int f = 0; f < 2; f++) add_frame($urandom_range(5, 15), ModeMix);
    add_frame(10, ModeNoise);

    drain();
    $display("sent %0d boxes: %0d kept, %0d suppressed, %0d list overflows",
             boxes_sent, kept_seen, suppressed_seen, full_seen);
    $display("%0d results at the saturated box number, thresholds 0 to max", saturated_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // box driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     = 0;
      boxes_sent = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_verdicts = {expected_verdicts, judge_box(held_box)};
        boxes_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_boxes.size() != 0) begin
          held_box = pending_boxes.pop_front();
          frame_start_i <= held_box.frame_start;
          box_left_i    <= held_box.left;
          box_top_i     <= held_box.top;
          box_width_i   <= held_box.width;
          box_height_i  <= held_box.height;
          in_valid_i    <= 1'b1;
          in_gap = no_idle ? 0 : $urandom_range(0, 5);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and back pressure
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall       = 0;
      kept_seen       = 0;
      suppressed_seen = 0;
      full_seen       = 0;
      saturated_seen  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          report("unexpected word", keep_o, -1);
        end else begin
          want = expected_verdicts.pop_front();
          if (keep_o !== want.keep) report("keep", keep_o, want.keep);
          if (box_number_o !== want.number) report("box_number", box_number_o, want.number);
          if (store_full_o !== want.full) report("store_full", store_full_o, want.full);
          if (want.keep) kept_seen++; else suppressed_seen++;
          if (want.full) full_seen++;
          if (want.number == NumberTop) saturated_seen++;
        end
        out_stall = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial cycles = 0;

endmodule
